// ===== hdl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and the microcode program of the page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  // field and entry widths
  localparam int VA_W       = 48;
  localparam int FRAME_W    = 40;
  localparam int ENTRY_W    = FRAME_W + 2;
  localparam int IDX_W      = 9;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int LEVEL_W    = 2;
  localparam int STEP_W     = 5;
  localparam int TABLE_POOL_DEFAULT = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_XLATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_TABLES = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT   = 2'd2;

  // entry flag bits: present and writable
  localparam logic [1:0] ENTRY_FLAGS = 2'b11;

  // write data select
  typedef enum logic [1:0] {
    WS_NONE,
    WS_ALLOC,
    WS_LEAF,
    WS_ZERO
  } wsel_t;

  // datapath action of one step
  typedef enum logic [2:0] {
    A_NONE,
    A_DESCEND,
    A_ALLOC,
    A_FRAME,
    A_NP,
    A_OOT,
    A_FIN
  } act_t;

  // jump condition
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CMD_BAD,
    C_ABSENT,
    C_LEVEL_LT2,
    C_NOT_MAP,
    C_FULL,
    C_CMD_MAP,
    C_CMD_UNMAP
  } cond_t;

  typedef struct packed {
    logic              rd;
    wsel_t             wsel;
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic cmd_bad;
    logic cmd_map;
    logic cmd_unmap;
    logic absent;
    logic full;
    logic level_lt2;
  } flags_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic  active;
    logic  rd;
    wsel_t wsel;
    act_t  act;
  } ctrl_t;

  // program addresses
  localparam logic [STEP_W-1:0] S_DISPATCH   = 5'd0;
  localparam logic [STEP_W-1:0] S_READ       = 5'd1;
  localparam logic [STEP_W-1:0] S_CHECK      = 5'd2;
  localparam logic [STEP_W-1:0] S_DESCEND    = 5'd3;
  localparam logic [STEP_W-1:0] S_TO_LEAF    = 5'd4;
  localparam logic [STEP_W-1:0] S_ABSENT     = 5'd5;
  localparam logic [STEP_W-1:0] S_FULL_CHK   = 5'd6;
  localparam logic [STEP_W-1:0] S_ALLOC      = 5'd7;
  localparam logic [STEP_W-1:0] S_LEAF       = 5'd8;
  localparam logic [STEP_W-1:0] S_LEAF_UNMAP = 5'd9;
  localparam logic [STEP_W-1:0] S_XL_READ    = 5'd10;
  localparam logic [STEP_W-1:0] S_XL_CHECK   = 5'd11;
  localparam logic [STEP_W-1:0] S_XL_FRAME   = 5'd12;
  localparam logic [STEP_W-1:0] S_ABS_UPPER  = 5'd13;
  localparam logic [STEP_W-1:0] S_NP         = 5'd14;
  localparam logic [STEP_W-1:0] S_OOT        = 5'd15;
  localparam logic [STEP_W-1:0] S_MAP_LEAF   = 5'd16;
  localparam logic [STEP_W-1:0] S_UNMAP_LEAF = 5'd17;
  localparam logic [STEP_W-1:0] S_FIN        = 5'd18;

  // microcode rom
  function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
    ucode_t w;
    w.rd     = 1'b0;
    w.wsel   = WS_NONE;
    w.act    = A_NONE;
    w.cond   = C_NEVER;
    w.target = S_FIN;
    case (step)
      S_DISPATCH: begin
        w.cond = C_CMD_BAD;
      end
      S_READ: begin
        w.rd = 1'b1;
      end
      S_CHECK: begin
        w.cond   = C_ABSENT;
        w.target = S_ABSENT;
      end
      S_DESCEND: begin
        w.act    = A_DESCEND;
        w.cond   = C_LEVEL_LT2;
        w.target = S_READ;
      end
      S_TO_LEAF: begin
        w.cond   = C_ALWAYS;
        w.target = S_LEAF;
      end
      S_ABSENT: begin
        w.cond   = C_NOT_MAP;
        w.target = S_ABS_UPPER;
      end
      S_FULL_CHK: begin
        w.cond   = C_FULL;
        w.target = S_OOT;
      end
      S_ALLOC: begin
        w.wsel   = WS_ALLOC;
        w.act    = A_ALLOC;
        w.cond   = C_LEVEL_LT2;
        w.target = S_READ;
      end
      S_LEAF: begin
        w.cond   = C_CMD_MAP;
        w.target = S_MAP_LEAF;
      end
      S_LEAF_UNMAP: begin
        w.cond   = C_CMD_UNMAP;
        w.target = S_UNMAP_LEAF;
      end
      S_XL_READ: begin
        w.rd = 1'b1;
      end
      S_XL_CHECK: begin
        w.cond   = C_ABSENT;
        w.target = S_NP;
      end
      S_XL_FRAME: begin
        w.act  = A_FRAME;
        w.cond = C_ALWAYS;
      end
      S_ABS_UPPER: begin
        // unmap over a missing level changes nothing, translate falls to not present
        w.cond = C_CMD_UNMAP;
      end
      S_NP: begin
        w.act  = A_NP;
        w.cond = C_ALWAYS;
      end
      S_OOT: begin
        w.act  = A_OOT;
        w.cond = C_ALWAYS;
      end
      S_MAP_LEAF: begin
        w.wsel = WS_LEAF;
        w.cond = C_ALWAYS;
      end
      S_UNMAP_LEAF: begin
        w.wsel = WS_ZERO;
        w.cond = C_ALWAYS;
      end
      default: begin
        w.act = A_FIN;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/four_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Map, unmap and translate over a pool of 512-entry page tables, walked
// four levels deep by a microcoded sequencer on one table memory port.
//
// Usage:
//   Request beats (command, vaddr, physical_frame) enter on
//   req_valid / req_stall; one response beat (status, frame_out) leaves on
//   rsp_valid / rsp_stall for every request.
//   A request runs one sequencer step a cycle from acceptance to
//   rsp_valid: three steps per upper level walked (read, check,
//   descend), five per level that map allocates, a few for the leaf,
//   set by the single table memory port. One request is in flight
//   at a time; req_stall is high while it runs and drops as its
//   response is loaded. After reset the table store is zeroed, one
//   entry a cycle, across the whole pool; req_stall stays high during
//   that pass. The response sits in an output register; a new request
//   is accepted while it waits. If rsp_stall holds a response, the next
//   request runs to its final step and waits there until the register
//   frees.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker
  import ptw_pkg::*;
#(
  parameter int TABLE_POOL = TABLE_POOL_DEFAULT,
  localparam int DEPTH     = TABLE_POOL * (2 ** IDX_W),
  localparam int AW        = $clog2(DEPTH),
  localparam int TW        = $clog2(TABLE_POOL),
  localparam int NFW       = $clog2(TABLE_POOL + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic [CMD_W-1:0]    command,
  input  wire logic [VA_W-1:0]     vaddr,
  input  wire logic [FRAME_W-1:0]  physical_frame,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output logic      [STATUS_W-1:0] status,
  output logic      [FRAME_W-1:0]  frame_out
);

  logic                req_fire;
  logic                emit_ok;
  logic                clearing;
  ctrl_t               ctrl;
  flags_t              flags;

  // request registers
  logic [CMD_W-1:0]    cmd_q;
  logic [VA_W-1:0]     va_q;
  logic [FRAME_W-1:0]  pf_q;

  // walk state
  logic [TW-1:0]       table_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [NFW-1:0]      next_free;
  logic [STATUS_W-1:0] res_status;
  logic [FRAME_W-1:0]  res_frame;

  // memory port
  logic [IDX_W-1:0]    idx;
  logic [AW-1:0]       addr;
  logic                wr_en;
  logic [ENTRY_W-1:0]  wr_data;
  logic [ENTRY_W-1:0]  rd_data;

  assign req_stall = ctrl.active | clearing;
  assign req_fire  = req_valid & ~req_stall;
  assign emit_ok   = ~rsp_valid | ~rsp_stall;

  // index of the current level
  always_comb begin
    case (level_q)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign addr = {table_q, idx};

  // write data select
  always_comb begin
    wr_en = 1'b1;
    case (ctrl.wsel)
      WS_ALLOC: wr_data = {FRAME_W'(next_free), ENTRY_FLAGS};
      WS_LEAF:  wr_data = {pf_q, ENTRY_FLAGS};
      WS_ZERO:  wr_data = '0;
      default: begin
        wr_data = '0;
        wr_en   = 1'b0;
      end
    endcase
  end

  // flags for the sequencer
  always_comb begin
    flags.cmd_bad   = (cmd_q == CMD_RSVD);
    flags.cmd_map   = (cmd_q == CMD_MAP);
    flags.cmd_unmap = (cmd_q == CMD_UNMAP);
    flags.absent    = ~rd_data[0];
    flags.full      = (next_free >= NFW'(TABLE_POOL));
    flags.level_lt2 = (level_q < 2'd2);
  end

  ptw_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (req_fire),
    .emit_ok (emit_ok),
    .flags   (flags),
    .ctrl    (ctrl)
  );

  ptw_store #(
    .TABLE_POOL (TABLE_POOL)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (ctrl.rd),
    .wr_en    (wr_en),
    .addr     (addr),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // request capture and walk datapath
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q      <= command;
      va_q       <= vaddr;
      pf_q       <= physical_frame;
      table_q    <= '0;
      level_q    <= '0;
      res_status <= ST_OK;
      res_frame  <= '0;
    end else begin
      case (ctrl.act)
        A_DESCEND: begin
          table_q <= rd_data[2 +: TW];
          level_q <= level_q + 1'b1;
        end
        A_ALLOC: begin
          table_q <= next_free[TW-1:0];
          level_q <= level_q + 1'b1;
        end
        A_FRAME:  res_frame  <= rd_data[ENTRY_W-1:2];
        A_NP:     res_status <= ST_NOT_PRESENT;
        A_OOT:    res_status <= ST_OUT_OF_TABLES;
        default: begin
        end
      endcase
    end
  end

  // bump allocator, root is table 0
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= NFW'(1);
    end else if (ctrl.act == A_ALLOC) begin
      next_free <= next_free + 1'b1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.act == A_FIN && emit_ok) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == A_FIN && emit_ok) begin
      status    <= res_status;
      frame_out <= res_frame;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ptw_store.sv =====
// ----------------------------------------------------------------------------
// ptw_store
// Table store: single port memory with registered read and a zeroing sweep
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_store
  import ptw_pkg::*;
#(
  parameter int TABLE_POOL = TABLE_POOL_DEFAULT,
  localparam int DEPTH     = TABLE_POOL * (2 ** IDX_W),
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rd_en,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  output logic      [ENTRY_W-1:0] rd_data,
  output logic                    clearing
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0]      clr_addr;

  // zeroing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // memory port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ptw_sequencer.sv =====
// ----------------------------------------------------------------------------
// ptw_sequencer
// Step counter over the microcode rom with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_sequencer
  import ptw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire logic   emit_ok,
  input  wire flags_t flags,
  output ctrl_t       ctrl
);

  logic              running;
  logic [STEP_W-1:0] step;
  ucode_t            word;
  logic              take;

  assign word = ucode_word(step);

  // jump condition
  always_comb begin
    case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_CMD_BAD:   take = flags.cmd_bad;
      C_ABSENT:    take = flags.absent;
      C_LEVEL_LT2: take = flags.level_lt2;
      C_NOT_MAP:   take = !flags.cmd_map;
      C_FULL:      take = flags.full;
      C_CMD_MAP:   take = flags.cmd_map;
      C_CMD_UNMAP: take = flags.cmd_unmap;
      default:     take = 1'b0;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= S_DISPATCH;
    end else if (start) begin
      running <= 1'b1;
      step    <= S_DISPATCH;
    end else if (running) begin
      if (word.act == A_FIN) begin
        if (emit_ok) begin
          running <= 1'b0;
        end
      end else if (take) begin
        step <= word.target;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  // control word, quiet while idle
  always_comb begin
    ctrl.active = running;
    ctrl.rd     = running & word.rd;
    ctrl.wsel   = running ? word.wsel : WS_NONE;
    ctrl.act    = running ? word.act : A_NONE;
  end

endmodule

`default_nettype wire

// ===== test/four_level_page_table_walker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_tb
// Drives map, translate, unmap and reserved requests into the walker with random gaps
// and response stalls, keeps a shadow page table pool that mirrors every
// accepted request, and checks each response beat against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------

module four_level_page_table_walker_tb;
  import ptw_pkg::*;

  localparam int POOL        = TABLE_POOL_DEFAULT;
  localparam int TABLE_SLOTS = 2 ** IDX_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [VA_W-1:0]    VA_LAST    = {VA_W{1'b1}};
  localparam logic [FRAME_W-1:0] FRAME_ONES = {FRAME_W{1'b1}};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
  } walk_result_t;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [CMD_W-1:0]    command;
  logic [VA_W-1:0]     vaddr;
  logic [FRAME_W-1:0]  physical_frame;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  frame_out;

  // shadow copy of the table pool and the allocation counter
  bit [ENTRY_W-1:0] shadow_tables [POOL*TABLE_SLOTS];
  int               next_table = 1;

  walk_result_t expected_results [$];
  walk_result_t head_result;

  bit idle_on          = 1'b1;
  int beat_delay       = 0;
  int long_hold_cycles = 0;
  int mismatch_count   = 0;
  int cycle_count      = 0;
  int map_count        = 0;
  int oot_count        = 0;
  int xlate_count      = 0;
  int hit_count        = 0;
  int unmap_count      = 0;
  int rsvd_count       = 0;

  four_level_page_table_walker dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .command         (command),
    .vaddr           (vaddr),
    .physical_frame  (physical_frame),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .frame_out       (frame_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- shadow model

  function automatic int level_index(input logic [VA_W-1:0] va, input int lvl);
    return int'(va[VA_W-1-IDX_W*lvl -: IDX_W]);
  endfunction

  function automatic int table_number(input bit [ENTRY_W-1:0] entry);
    return int'(entry[ENTRY_W-1:2] % POOL);
  endfunction

  // follow the three upper levels without allocating
  function automatic bit find_leaf_table(input logic [VA_W-1:0] va, output int tbl);
    bit [ENTRY_W-1:0] ent;
    tbl = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      ent = shadow_tables[tbl*TABLE_SLOTS + level_index(va, lvl)];
      if (!ent[0]) return 1'b0;
      tbl = table_number(ent);
    end
    return 1'b1;
  endfunction

  function automatic walk_result_t apply_request(input logic [CMD_W-1:0] cmd,
                                                 input logic [VA_W-1:0] va,
                                                 input logic [FRAME_W-1:0] pf);
    walk_result_t res;
    int           tbl;
    int           slot;
    bit           room;
    res.status = ST_OK;
    res.frame  = '0;
    tbl        = 0;
    slot       = -1;
    room       = 1'b1;
    case (cmd)
      CMD_MAP: begin
        // descend, taking a new table for each absent level
        for (int lvl = 0; lvl < 3 && room; lvl++) begin
          slot = tbl*TABLE_SLOTS + level_index(va, lvl);
          if (shadow_tables[slot][0]) begin
            tbl = table_number(shadow_tables[slot]);
          end else if (next_table >= POOL) begin
            room = 1'b0;
          end else begin
            shadow_tables[slot] = {FRAME_W'(next_table), ENTRY_FLAGS};
            tbl = next_table;
            next_table++;
          end
        end
        // tables taken before running dry stay in place
        if (room) begin
          shadow_tables[tbl*TABLE_SLOTS + level_index(va, 3)] = {pf, ENTRY_FLAGS};
        end else begin
          res.status = ST_OUT_OF_TABLES;
        end
      end
      CMD_XLATE: begin
        if (find_leaf_table(va, tbl)) slot = tbl*TABLE_SLOTS + level_index(va, 3);
        if (slot >= 0 && shadow_tables[slot][0]) begin
          res.frame = shadow_tables[slot][ENTRY_W-1:2];
        end else begin
          res.status = ST_NOT_PRESENT;
        end
      end
      CMD_UNMAP: begin
        // leaf is cleared even if it was already absent
        if (find_leaf_table(va, tbl)) shadow_tables[tbl*TABLE_SLOTS + level_index(va, 3)] = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_MAP;
    else if (r < 75) return CMD_XLATE;
    else if (r < 95) return CMD_UNMAP;
    else return CMD_RSVD;
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FRAME_ONES;
      default: return raw[FRAME_W-1:0];
    endcase
  endfunction

  // index from a small shared set per level so walks land on existing tables
  function automatic logic [IDX_W-1:0] shared_index(input int lvl);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return (lvl == 0) ? '1 : IDX_W'(5);
      default: return '1;
    endcase
  endfunction

  function automatic logic [VA_W-1:0] pick_address(input bit shared_only);
    logic [63:0]     raw;
    logic [VA_W-1:0] va;
    raw = {$urandom, $urandom};
    va  = raw[VA_W-1:0];
    if (shared_only || $urandom_range(0, 9) != 0) begin
      for (int lvl = 0; lvl < 3; lvl++) va[VA_W-1-IDX_W*lvl -: IDX_W] = shared_index(lvl);
      va[12 +: IDX_W] = IDX_W'($urandom_range(0, 7));
    end
    return va;
  endfunction

  // a path with a top-level index outside the shared set
  function automatic logic [VA_W-1:0] fresh_path(input int k);
    logic [VA_W-1:0] va;
    va = '0;
    va[VA_W-1 -: IDX_W] = IDX_W'(100 + k);
    va[30 +: IDX_W]     = IDX_W'(k);
    va[21 +: IDX_W]     = IDX_W'(k);
    va[12 +: IDX_W]     = IDX_W'(k);
    return va;
  endfunction

  // ---------------------------------------------------------------- request side

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VA_W-1:0] va,
                              input logic [FRAME_W-1:0] pf);
    int           gap;
    walk_result_t res;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command         <= cmd;
    vaddr           <= va;
    physical_frame  <= pf;
    req_valid       <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    res = apply_request(cmd, va, pf);
    expected_results.push_back(res);
    case (cmd)
      CMD_MAP: begin
        map_count++;
        if (res.status == ST_OUT_OF_TABLES) oot_count++;
      end
      CMD_XLATE: begin
        xlate_count++;
        if (res.status == ST_OK) hit_count++;
      end
      CMD_UNMAP: unmap_count++;
      default:   rsvd_count++;
    endcase
  endtask

  // ---------------------------------------------------------------- response side

  // per-beat stall once valid shows, plus an optional long hold
  always @(negedge clk) begin
    if (long_hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      long_hold_cycles--;
    end else if (rsp_valid && beat_delay > 0) begin
      rsp_stall <= 1'b1;
      beat_delay--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // compare each accepted beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual status %0d frame %h",
                 $time, status, frame_out);
        mismatch_count++;
      end else begin
        head_result = expected_results.pop_front();
        if (status !== head_result.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, head_result.status, status);
          mismatch_count++;
        end
        if (frame_out !== head_result.frame) begin
          $display("%0t: frame_out mismatch, expected %h actual %h",
                   $time, head_result.frame, frame_out);
          mismatch_count++;
        end
      end
      beat_delay = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_basic_walks();
    send_request(CMD_XLATE, '0, '0);                       // empty root
    send_request(CMD_UNMAP, '0, '0);                       // upper level absent
    send_request(CMD_MAP, '0, FRAME_ONES);
    send_request(CMD_XLATE, 48'h0000_0000_0ABC, '0);       // offset bits ignored
    send_request(CMD_MAP, VA_LAST, '0);
    send_request(CMD_XLATE, VA_LAST, FRAME_ONES);
    send_request(CMD_MAP, 48'h0000_0000_1FFF, 40'h55_5555_5555);  // neighbor leaf
    send_request(CMD_MAP, '0, 40'hAA_AAAA_AAAA);           // remap over present leaf
    send_request(CMD_XLATE, '0, '0);
    send_request(CMD_XLATE, 48'h0000_0000_1000, '0);
    send_request(CMD_UNMAP, 48'h0000_0000_0FFF, '0);
    send_request(CMD_XLATE, '0, '0);
    send_request(CMD_UNMAP, '0, '0);                       // leaf already absent
    send_request(CMD_RSVD, VA_LAST, FRAME_ONES);
    send_request(CMD_XLATE, VA_LAST, '0);
    send_request(CMD_UNMAP, 48'h0000_0020_0000, '0);       // third level absent
    send_request(CMD_XLATE, 48'h8000_0000_0000, '0);
  endtask

  task automatic test_random_traffic(input int count, input bit fresh_maps);
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      cmd = pick_command();
      send_request(cmd, pick_address(cmd == CMD_MAP && !fresh_maps), pick_frame());
    end
  endtask

  task automatic test_pool_exhaustion();
    int k;
    k = 0;
    // fresh paths until the pool runs dry, the last one possibly part way
    while (next_table < POOL && k < 30) begin
      send_request(CMD_MAP, fresh_path(k), pick_frame());
      k++;
    end
    send_request(CMD_MAP, fresh_path(k), pick_frame());
    send_request(CMD_XLATE, fresh_path(k), '0);
    send_request(CMD_UNMAP, fresh_path(k), '0);
    send_request(CMD_MAP, '0, pick_frame());               // existing path still maps
    send_request(CMD_XLATE, '0, '0);
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    test_random_traffic(count, 1'b1);
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    @(posedge clk);
    long_hold_cycles = 300;
    test_random_traffic(12, 1'b1);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst             = 1'b1;
    req_valid       = 1'b0;
    command         = CMD_XLATE;
    vaddr           = '0;
    physical_frame  = '0;
    rsp_stall       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_walks();
    test_random_traffic(800, 1'b0);
    test_pool_exhaustion();
    test_back_to_back(150);
    test_output_backpressure();
    test_random_traffic(800, 1'b1);

    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d maps (%0d out of tables), %0d translates (%0d hits),",
             map_count, oot_count, xlate_count, hit_count);
    $display("%0d unmaps, %0d reserved commands, %0d of %0d tables allocated",
             unmap_count, rsvd_count, next_table, POOL);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
